// ===== rtl/core/tgad_pkg.sv =====
// Package for the TGA RLE pixel decoder: payload structs, codes, color helpers.
// No dependencies.
package tgad_pkg;

    localparam int MapEntries = 256;
    localparam int MaxWidth   = 4096;
    localparam int MaxHeight  = 4096;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_MAP   = 2'd1;
    localparam logic [1:0] CMD_PIXEL = 2'd2;

    localparam logic [2:0] REG_KIND   = 3'd0;
    localparam logic [2:0] REG_RLE    = 3'd1;
    localparam logic [2:0] REG_PDEPTH = 3'd2;
    localparam logic [2:0] REG_MDEPTH = 3'd3;
    localparam logic [2:0] REG_FIRST  = 3'd4;
    localparam logic [2:0] REG_WIDTH  = 3'd5;
    localparam logic [2:0] REG_HEIGHT = 3'd6;
    localparam logic [2:0] REG_ORIENT = 3'd7;

    localparam logic [1:0] KIND_MAPPED = 2'd0;
    localparam logic [1:0] KIND_TRUE   = 2'd1;

    localparam logic [2:0] PDEPTH_8  = 3'd0;
    localparam logic [2:0] PDEPTH_15 = 3'd1;
    localparam logic [2:0] PDEPTH_16 = 3'd2;
    localparam logic [2:0] PDEPTH_24 = 3'd3;
    localparam logic [2:0] PDEPTH_32 = 3'd4;

    localparam logic [1:0] MDEPTH_15 = 2'd0;
    localparam logic [1:0] MDEPTH_16 = 2'd1;
    localparam logic [1:0] MDEPTH_24 = 2'd2;
    localparam logic [1:0] MDEPTH_32 = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pixel_rgba;
        logic [11:0] dest_row;
        logic [11:0] dest_col;
        logic [7:0]  run_count;
        logic        index_error;
        logic        frame_done;
        logic        last_segment;
    } out_item_t;

    function automatic logic [7:0] expand5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

    function automatic logic [31:0] from16(input logic [15:0] c, input logic has_alpha);
        logic [7:0] a;
        a = has_alpha ? {8{c[15]}} : 8'hff;
        return {a, expand5(c[4:0]), expand5(c[9:5]), expand5(c[14:10])};
    endfunction

    function automatic logic [31:0] from24(input logic [23:0] v, input logic [7:0] a);
        return {a, v[7:0], v[15:8], v[23:16]};
    endfunction

endpackage

// ===== rtl/core/tga_rle_pixel_decoder.sv =====
// Top level of the TGA RLE pixel decoder: byte gathering, packet control,
// color map lookup and line splitting. Depends on tgad_pkg and tgad_table.
//
//  Channel  Ports            Direction  Contents
//  input    s_valid/s_ready  in         in_item_t: command, data_byte
//  result   m_valid/m_ready  out        out_item_t: one run segment
//  config   cfg_we/idx/data  in         register writes, no read-back
//
// Bytes that complete no pixel are accepted one per cycle. A completed pixel passes
// through the color lookup state (map RAM read latency), then segments are emitted
// one per cycle while the output accepts, up to 17 for a run that spans short lines.
// Reset is synchronous; the map RAM is not cleared, the fill count guards it.
// A full output register stalls segment emission; input waits until done.
module tga_rle_pixel_decoder #(
    parameter int MAP_ENTRIES = tgad_pkg::MapEntries,
    parameter int MAX_WIDTH   = tgad_pkg::MaxWidth
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tgad_pkg::in_item_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tgad_pkg::out_item_t m_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_idx,
    input  logic [15:0]        cfg_data
);
    localparam int AW = $clog2(MAP_ENTRIES);
    localparam int FW = $clog2(MAP_ENTRIES + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_EMIT} state_t;

    // configuration
    logic [1:0]  kind_reg;
    logic        rle_reg;
    logic [2:0]  pdepth_reg;
    logic [1:0]  mdepth_reg;
    logic [15:0] first_reg;
    logic [12:0] width_reg, height_reg;
    logic [1:0]  orient_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg   <= tgad_pkg::KIND_TRUE;
            rle_reg    <= 1'b0;
            pdepth_reg <= tgad_pkg::PDEPTH_32;
            mdepth_reg <= tgad_pkg::MDEPTH_24;
            first_reg  <= '0;
            width_reg  <= 13'd8;
            height_reg <= 13'd1;
            orient_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                tgad_pkg::REG_KIND:   kind_reg   <= cfg_data[1:0];
                tgad_pkg::REG_RLE:    rle_reg    <= cfg_data[0];
                tgad_pkg::REG_PDEPTH: pdepth_reg <= cfg_data[2:0];
                tgad_pkg::REG_MDEPTH: mdepth_reg <= cfg_data[1:0];
                tgad_pkg::REG_FIRST:  first_reg  <= cfg_data;
                tgad_pkg::REG_WIDTH:  width_reg  <= cfg_data[12:0];
                tgad_pkg::REG_HEIGHT: height_reg <= cfg_data[12:0];
                tgad_pkg::REG_ORIENT: orient_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Effective dimensions, clamped; computed from static config.
    logic [WW-1:0] w_eff;
    logic [12:0]   h_eff;
    always_comb begin
        if (width_reg == '0) w_eff = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
        else w_eff = WW'(width_reg);
        if (height_reg == '0) h_eff = 13'd1;
        else if (height_reg > 13'd4096) h_eff = 13'd4096;
        else h_eff = height_reg;
    end

    // state
    state_t        state_reg;
    logic [FW-1:0] fill_reg;
    logic [23:0]   gather_reg;
    logic [1:0]    gcnt_reg;
    logic [7:0]    raw_left_reg, run_pend_reg;
    logic [12:0]   row_reg;
    logic [WW-1:0] col_reg;
    logic          finished_reg;
    // pixel in flight
    logic [31:0]   value_reg;
    logic          is_map_reg, err_reg, map_ok_reg;
    logic [7:0]    count_reg;
    logic [31:0]   rgba_reg;
    logic [4:0]    seg_reg;
    logic          m_valid_reg;
    tgad_pkg::out_item_t m_data_reg;

    logic          tbl_we;
    logic [AW-1:0] tbl_waddr, tbl_raddr;
    logic [31:0]   tbl_wdata, tbl_rdata;

    tgad_table #(.ENTRIES(MAP_ENTRIES)) u_table (
        .aclk(aclk), .wr_en(tbl_we), .wr_addr(tbl_waddr), .wr_data(tbl_wdata),
        .rd_addr(tbl_raddr), .rd_data(tbl_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Gather decode for the incoming byte.
    logic [2:0]  pcode;
    logic [2:0]  nbytes;
    logic        done;
    logic [31:0] full;
    logic [1:0]  cmd;
    logic [7:0]  b;
    logic        hdr;
    logic [32:0] idx_diff;
    logic [31:0] conv;

    assign cmd   = s_data.command;
    assign b     = s_data.data_byte;
    assign pcode = (pdepth_reg > tgad_pkg::PDEPTH_32) ? tgad_pkg::PDEPTH_32 : pdepth_reg;
    assign hdr   = rle_reg && raw_left_reg == '0 && run_pend_reg == '0;

    always_comb begin
        if (cmd == tgad_pkg::CMD_MAP) begin
            case (mdepth_reg)
                tgad_pkg::MDEPTH_24: nbytes = 3'd3;
                tgad_pkg::MDEPTH_32: nbytes = 3'd4;
                default:             nbytes = 3'd2;
            endcase
        end else begin
            case (pcode)
                tgad_pkg::PDEPTH_8:                      nbytes = 3'd1;
                tgad_pkg::PDEPTH_15, tgad_pkg::PDEPTH_16: nbytes = 3'd2;
                tgad_pkg::PDEPTH_24:                     nbytes = 3'd3;
                default:                                 nbytes = 3'd4;
            endcase
        end
        done = (3'(gcnt_reg) + 3'd1) >= nbytes;
        full = {8'd0, gather_reg} | (32'(b) << {gcnt_reg, 3'b000});
    end

    // Map entry conversion.
    always_comb begin
        case (mdepth_reg)
            tgad_pkg::MDEPTH_15: conv = tgad_pkg::from16(full[15:0], 1'b0);
            tgad_pkg::MDEPTH_16: conv = tgad_pkg::from16(full[15:0], 1'b1);
            tgad_pkg::MDEPTH_24: conv = tgad_pkg::from24(full[23:0], 8'hff);
            default:             conv = tgad_pkg::from24(full[23:0], full[31:24]);
        endcase
    end

    assign tbl_we    = state_reg == ST_IDLE && s_valid && cmd == tgad_pkg::CMD_MAP && done
                       && 32'(fill_reg) < MAP_ENTRIES;
    assign tbl_waddr = fill_reg[AW-1:0];
    assign tbl_wdata = conv;
    // The full pixel value is used, so wide indices above the first index still hit.
    assign idx_diff  = {1'b0, value_reg} - {17'd0, first_reg};
    assign tbl_raddr = idx_diff[AW-1:0];

    // Segment math.
    logic [WW-1:0] room;
    logic [7:0]    n;
    logic [WW-1:0] col_next;
    logic          line_end, last_line, seg_last;
    always_comb begin
        room      = w_eff - col_reg;
        n         = (32'(room) < 32'(count_reg)) ? 8'(room) : count_reg;
        col_next  = col_reg + WW'(n);
        line_end  = col_next >= w_eff;
        last_line = line_end && (row_reg + 13'd1 >= h_eff);
        seg_last  = (n == count_reg) || last_line || seg_reg == 5'd16;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            gather_reg   <= '0;
            gcnt_reg     <= '0;
            raw_left_reg <= '0;
            run_pend_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            finished_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // While emitting, the segment branch below owns the valid flag.
            if (m_valid_reg && m_ready && state_reg != ST_EMIT) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        case (cmd)
                            tgad_pkg::CMD_START: begin
                                fill_reg     <= '0;
                                gather_reg   <= '0;
                                gcnt_reg     <= '0;
                                raw_left_reg <= '0;
                                run_pend_reg <= '0;
                                row_reg      <= '0;
                                col_reg      <= '0;
                                finished_reg <= 1'b0;
                            end
                            tgad_pkg::CMD_MAP: begin
                                if (done) begin
                                    gather_reg <= '0;
                                    gcnt_reg   <= '0;
                                    if (32'(fill_reg) < MAP_ENTRIES) fill_reg <= fill_reg + FW'(1);
                                end else begin
                                    gather_reg <= full[23:0];
                                    gcnt_reg   <= gcnt_reg + 2'd1;
                                end
                            end
                            tgad_pkg::CMD_PIXEL: begin
                                if (!finished_reg) begin
                                    if (hdr) begin
                                        if (b[7]) run_pend_reg <= b - 8'd127;
                                        else raw_left_reg <= b + 8'd1;
                                    end else if (done) begin
                                        gather_reg <= '0;
                                        gcnt_reg   <= '0;
                                        value_reg  <= full;
                                        if (run_pend_reg != '0) begin
                                            count_reg    <= run_pend_reg;
                                            run_pend_reg <= '0;
                                        end else begin
                                            count_reg <= 8'd1;
                                            if (raw_left_reg != '0)
                                                raw_left_reg <= raw_left_reg - 8'd1;
                                        end
                                        state_reg <= ST_LOOK;
                                    end else begin
                                        gather_reg <= full[23:0];
                                        gcnt_reg   <= gcnt_reg + 2'd1;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_LOOK: begin
                    // Table read for value_reg is issued this cycle.
                    seg_reg <= '0;
                    is_map_reg <= kind_reg == tgad_pkg::KIND_MAPPED;
                    map_ok_reg <= !idx_diff[32] && idx_diff[31:0] < 32'(fill_reg);
                    err_reg <= kind_reg == tgad_pkg::KIND_TRUE && pcode == tgad_pkg::PDEPTH_8;
                    case (kind_reg)
                        tgad_pkg::KIND_MAPPED: rgba_reg <= '0;
                        tgad_pkg::KIND_TRUE: begin
                            case (pcode)
                                tgad_pkg::PDEPTH_8: rgba_reg <= '0;
                                tgad_pkg::PDEPTH_15:
                                    rgba_reg <= tgad_pkg::from16(value_reg[15:0], 1'b0);
                                tgad_pkg::PDEPTH_16:
                                    rgba_reg <= tgad_pkg::from16(value_reg[15:0], 1'b1);
                                tgad_pkg::PDEPTH_24:
                                    rgba_reg <= tgad_pkg::from24(value_reg[23:0], 8'hff);
                                default: rgba_reg <= tgad_pkg::from24(value_reg[23:0],
                                                                     value_reg[31:24]);
                            endcase
                        end
                        default: rgba_reg <= {4{value_reg[7:0]}};
                    endcase
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        if (is_map_reg) begin
                            m_data_reg.pixel_rgba  <= map_ok_reg ? tbl_rdata : '0;
                            m_data_reg.index_error <= !map_ok_reg;
                            rgba_reg <= map_ok_reg ? tbl_rdata : '0;
                            err_reg  <= !map_ok_reg;
                            is_map_reg <= 1'b0;
                        end else begin
                            m_data_reg.pixel_rgba  <= rgba_reg;
                            m_data_reg.index_error <= err_reg;
                        end
                        m_data_reg.dest_row <= orient_reg[0] ? row_reg[11:0]
                                               : 12'(h_eff - 13'd1 - row_reg);
                        m_data_reg.dest_col <= orient_reg[1] ? 12'(w_eff - WW'(1) - col_reg)
                                               : 12'(col_reg);
                        m_data_reg.run_count    <= n;
                        m_data_reg.frame_done   <= last_line;
                        m_data_reg.last_segment <= seg_last;
                        count_reg <= count_reg - n;
                        seg_reg   <= seg_reg + 5'd1;
                        if (line_end) begin
                            col_reg <= '0;
                            row_reg <= row_reg + 13'd1;
                            if (last_line) finished_reg <= 1'b1;
                        end else begin
                            col_reg <= col_next;
                        end
                        if (seg_last) state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/tgad_table.sv =====
// Color map RAM of the TGA decoder: one write port, one registered read port.
// Depends on tgad_pkg for nothing but sizing defaults.
module tgad_table #(
    parameter int ENTRIES = tgad_pkg::MapEntries
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  logic [31:0]                wr_data,
    input  logic [$clog2(ENTRIES)-1:0] rd_addr,
    output logic [31:0]                rd_data
);
    logic [31:0] mem [ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
